// ----- design/rtmp_chp_pkg.sv -----
// Shared types, codes and helpers for the RTMP chunk header parser.
package rtmp_chp_pkg;

  localparam int STREAM_SLOTS_DEF = 1024;

  localparam int STREAM_W = 17;
  localparam int TIME_W   = 24;

  // Chunk header formats (top two bits of the first byte)
  localparam logic [1:0] FMT_FULL      = 2'd0;
  localparam logic [1:0] FMT_NO_STREAM = 2'd1;
  localparam logic [1:0] FMT_TIME_ONLY = 2'd2;
  localparam logic [1:0] FMT_NONE      = 2'd3;

  // Low six bits of the first byte that select the long basic forms
  localparam logic [5:0] LOW_TWO_BYTE   = 6'd0;
  localparam logic [5:0] LOW_THREE_BYTE = 6'd1;

  localparam logic [STREAM_W-1:0] LONG_ID_BASE = 17'd64;
  localparam logic [TIME_W-1:0]   TIME_ESCAPE  = 24'hFFFFFF;
  localparam logic [3:0]          EXT_BYTES    = 4'd4;

  typedef enum logic [5:0] {
    PH_BASIC0 = 6'b000001,
    PH_BASIC1 = 6'b000010,
    PH_BASIC2 = 6'b000100,
    PH_MSG    = 6'b001000,
    PH_EXT    = 6'b010000,
    PH_FLAG   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]          fmt;
    logic [STREAM_W-1:0] stream;
    logic [TIME_W-1:0]   time_acc;
    logic [23:0]         len;
    logic [7:0]          msg_type;
    logic [31:0]         msg_stream;
    logic [31:0]         ext;
    logic [1:0]          blen;
  } hdr_t;

  function automatic logic [3:0] msg_bytes(input logic [1:0] fmt);
    logic [3:0] n;
    case (fmt)
      FMT_FULL:      n = 4'd11;
      FMT_NO_STREAM: n = 4'd7;
      FMT_TIME_ONLY: n = 4'd3;
      default:       n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- design/rtmp_chp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rtmp_chp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/rtmp_chunk_header_parser_unit.sv -----
// RTMP chunk header parser: byte-wise header decode with a per-stream extended-timestamp flag RAM.
//
// Takes one header byte per cycle, back to back, while in_stall is low, and emits one word per
// completed chunk header via a result register. Format 3 headers look up their chunk stream's
// extended flag in the flag RAM; the read issues on the last basic-header byte and resolves
// once the output is free, accepting the following byte in that same cycle if one is offered.
// A format 3 header that reads no extended timestamp therefore emits at that lookup, not with
// its last byte like the others. A word waiting at a stalled output holds the input off.
// After reset the flag RAM clears every entry, one per cycle; in_stall is high until it is done.
module rtmp_chunk_header_parser_unit #(
  parameter int STREAM_SLOTS = rtmp_chp_pkg::STREAM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_header_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_chunk_format,
  output logic [16:0] out_chunk_stream,
  output logic [23:0] out_time_field,
  output logic [23:0] out_message_length,
  output logic [7:0]  out_message_type,
  output logic [31:0] out_message_stream,
  output logic [31:0] out_extended_time,
  output logic        out_ext_read,
  output logic [1:0]  out_basic_size,
  output logic [3:0]  out_message_header_bytes,
  output logic [23:0] out_payload_bytes
);

  localparam int AW = $clog2(STREAM_SLOTS);
  localparam logic [rtmp_chp_pkg::STREAM_W-1:0] SLOTS_ID = 17'(STREAM_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(STREAM_SLOTS - 1);

  rtmp_chp_pkg::phase_t phase_r, phase_nxt, eff_phase;
  rtmp_chp_pkg::hdr_t   hdr_r, hdr_nxt, src;
  logic [3:0]           idx_r, idx_nxt;

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          fwd_hit_r, fwd_data_r;
  logic          out_valid_r;

  logic          slot_free, in_acc;
  logic          flag_emit, byte_emit, emit, emit_ext;
  logic          flag_set, src_in_range;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    b;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = clr_busy_r || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign b         = in_header_byte;

  // Stream ids beyond the table never carry a flag
  assign flag_set = (hdr_r.stream < SLOTS_ID) && (fwd_hit_r ? fwd_data_r : ram_rdata);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    hdr_nxt   = hdr_r;
    eff_phase = phase_r;
    flag_emit = 1'b0;
    byte_emit = 1'b0;
    emit_ext  = 1'b0;
    rd_en     = 1'b0;

    // Resolve a pending format 3 lookup; the byte of this cycle follows it
    if (phase_r == rtmp_chp_pkg::PH_FLAG && slot_free) begin
      idx_nxt = 4'd0;
      if (flag_set) begin
        phase_nxt = rtmp_chp_pkg::PH_EXT;
        eff_phase = rtmp_chp_pkg::PH_EXT;
      end else begin
        flag_emit = 1'b1;
        phase_nxt = rtmp_chp_pkg::PH_BASIC0;
        eff_phase = rtmp_chp_pkg::PH_BASIC0;
      end
    end

    if (in_acc) begin
      unique case (eff_phase)
        rtmp_chp_pkg::PH_BASIC0: begin
          hdr_nxt.fmt        = b[7:6];
          hdr_nxt.time_acc   = '0;
          hdr_nxt.len        = '0;
          hdr_nxt.msg_type   = '0;
          hdr_nxt.msg_stream = '0;
          hdr_nxt.ext        = '0;
          idx_nxt            = 4'd0;
          if (b[5:0] == rtmp_chp_pkg::LOW_TWO_BYTE || b[5:0] == rtmp_chp_pkg::LOW_THREE_BYTE) begin
            hdr_nxt.blen   = (b[5:0] == rtmp_chp_pkg::LOW_TWO_BYTE) ? 2'd2 : 2'd3;
            hdr_nxt.stream = rtmp_chp_pkg::LONG_ID_BASE;
            phase_nxt      = rtmp_chp_pkg::PH_BASIC1;
          end else begin
            hdr_nxt.blen   = 2'd1;
            hdr_nxt.stream = 17'(b[5:0]);
            if (hdr_nxt.fmt != rtmp_chp_pkg::FMT_NONE) begin
              phase_nxt = rtmp_chp_pkg::PH_MSG;
            end else begin
              phase_nxt = rtmp_chp_pkg::PH_FLAG;
              rd_en     = 1'b1;
            end
          end
        end
        rtmp_chp_pkg::PH_BASIC1: begin
          hdr_nxt.stream = rtmp_chp_pkg::LONG_ID_BASE + 17'(b);
          idx_nxt        = 4'd0;
          if (hdr_r.blen == 2'd3) begin
            phase_nxt = rtmp_chp_pkg::PH_BASIC2;
          end else if (hdr_r.fmt != rtmp_chp_pkg::FMT_NONE) begin
            phase_nxt = rtmp_chp_pkg::PH_MSG;
          end else begin
            phase_nxt = rtmp_chp_pkg::PH_FLAG;
            rd_en     = 1'b1;
          end
        end
        rtmp_chp_pkg::PH_BASIC2: begin
          hdr_nxt.stream = hdr_r.stream + {1'b0, b, 8'h00};
          idx_nxt        = 4'd0;
          if (hdr_r.fmt != rtmp_chp_pkg::FMT_NONE) begin
            phase_nxt = rtmp_chp_pkg::PH_MSG;
          end else begin
            phase_nxt = rtmp_chp_pkg::PH_FLAG;
            rd_en     = 1'b1;
          end
        end
        rtmp_chp_pkg::PH_MSG: begin
          if (idx_r < 4'd3) begin
            hdr_nxt.time_acc = {hdr_r.time_acc[15:0], b};
          end else if (idx_r < 4'd6) begin
            hdr_nxt.len = {hdr_r.len[15:0], b};
          end else begin
            case (idx_r)
              4'd6:    hdr_nxt.msg_type          = b;
              4'd7:    hdr_nxt.msg_stream[7:0]   = b;
              4'd8:    hdr_nxt.msg_stream[15:8]  = b;
              4'd9:    hdr_nxt.msg_stream[23:16] = b;
              4'd10:   hdr_nxt.msg_stream[31:24] = b;
              default: hdr_nxt.msg_type          = hdr_r.msg_type;
            endcase
          end
          idx_nxt = idx_r + 4'd1;
          if (idx_nxt >= rtmp_chp_pkg::msg_bytes(hdr_r.fmt)) begin
            idx_nxt = 4'd0;
            if (hdr_nxt.time_acc == rtmp_chp_pkg::TIME_ESCAPE) begin
              phase_nxt = rtmp_chp_pkg::PH_EXT;
            end else begin
              byte_emit = 1'b1;
              phase_nxt = rtmp_chp_pkg::PH_BASIC0;
            end
          end
        end
        rtmp_chp_pkg::PH_EXT: begin
          hdr_nxt.ext = {hdr_r.ext[23:0], b};
          idx_nxt     = idx_nxt + 4'd1;
          if (idx_nxt >= rtmp_chp_pkg::EXT_BYTES) begin
            idx_nxt   = 4'd0;
            byte_emit = 1'b1;
            emit_ext  = 1'b1;
            phase_nxt = rtmp_chp_pkg::PH_BASIC0;
          end
        end
        default: begin
          idx_nxt   = 4'd0;
          phase_nxt = rtmp_chp_pkg::PH_BASIC0;
        end
      endcase
    end
  end

  assign emit         = flag_emit || byte_emit;
  assign src          = flag_emit ? hdr_r : hdr_nxt;
  assign src_in_range = src.stream < SLOTS_ID;
  assign rd_addr      = hdr_nxt.stream[AW-1:0];

  // Clearing pass owns the write port until it ends
  assign ram_we    = clr_busy_r || (emit && src_in_range);
  assign ram_waddr = clr_busy_r ? clr_addr_r : src.stream[AW-1:0];
  assign ram_wdata = clr_busy_r ? 1'b0 : emit_ext;

  rtmp_chp_ram #(
    .WIDTH (1),
    .DEPTH (STREAM_SLOTS),
    .AW    (AW)
  ) u_flag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rtmp_chp_pkg::PH_BASIC0;
      idx_r       <= '0;
      hdr_r       <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      fwd_hit_r   <= 1'b0;
      fwd_data_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      hdr_r   <= hdr_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_SLOT) begin
          clr_busy_r <= 1'b0;
        end
      end
      // Forward a write that lands on the entry being read in the same cycle
      if (rd_en) begin
        fwd_hit_r  <= ram_we && (ram_waddr == rd_addr);
        fwd_data_r <= ram_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on emit, hold otherwise
  always_ff @(posedge clk) begin
    if (emit) begin
      out_chunk_format   <= src.fmt;
      out_chunk_stream   <= src.stream;
      out_time_field     <= (src.fmt != rtmp_chp_pkg::FMT_NONE) ? src.time_acc : '0;
      out_message_length <= (src.fmt == rtmp_chp_pkg::FMT_FULL ||
                             src.fmt == rtmp_chp_pkg::FMT_NO_STREAM) ? src.len : '0;
      out_message_type   <= (src.fmt == rtmp_chp_pkg::FMT_FULL ||
                             src.fmt == rtmp_chp_pkg::FMT_NO_STREAM) ? src.msg_type : '0;
      out_message_stream <= (src.fmt == rtmp_chp_pkg::FMT_FULL) ? src.msg_stream : '0;
      out_extended_time  <= emit_ext ? src.ext : '0;
      out_ext_read       <= emit_ext;
      out_basic_size     <= src.blen;
      out_message_header_bytes <= rtmp_chp_pkg::msg_bytes(src.fmt);
      out_payload_bytes  <= (src.fmt == rtmp_chp_pkg::FMT_FULL ||
                             src.fmt == rtmp_chp_pkg::FMT_NO_STREAM) ? src.len : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/rtmp_chp_checker.sv -----
// Port-level checks for the RTMP chunk header parser, bound to the top level.
module rtmp_chp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_header_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_chunk_format,
  input logic [16:0] out_chunk_stream,
  input logic [23:0] out_time_field,
  input logic [23:0] out_message_length,
  input logic [7:0]  out_message_type,
  input logic [31:0] out_message_stream,
  input logic [31:0] out_extended_time,
  input logic        out_ext_read,
  input logic [1:0]  out_basic_size,
  input logic [3:0]  out_message_header_bytes,
  input logic [23:0] out_payload_bytes
);

  // A stalled word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chunk_stream) &&
      $stable(out_extended_time))
    else $error("stalled result word dropped or changed");

  a_hdr_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_message_header_bytes == rtmp_chp_pkg::msg_bytes(out_chunk_format) &&
      out_basic_size != 2'd0)
    else $error("header sizes disagree with format");

  a_fmt_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_format == rtmp_chp_pkg::FMT_NONE |->
      out_time_field == '0 && out_payload_bytes == '0 && out_message_type == '0)
    else $error("format 3 word carries message header fields");

  a_ext_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ext_read |-> out_extended_time == '0 &&
      out_payload_bytes == out_message_length)
    else $error("extended time or payload size inconsistent");

endmodule

bind rtmp_chunk_header_parser_unit rtmp_chp_checker u_rtmp_chp_checker (.*);

// ----- verif/tb_top.sv -----
// Testbench for the RTMP chunk header parser: byte-level predictor, scoreboard and stimulus.
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS        = rtmp_chp_pkg::STREAM_SLOTS_DEF;
  localparam int ITEM_TARGET  = 1850;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 32;

  // Message header length in bytes, indexed by chunk format
  localparam logic [3:0] MSG_SPAN [4] = '{4'd11, 4'd7, 4'd3, 4'd0};

  typedef struct {
    logic [1:0]  fmt;
    logic [16:0] stream;
    logic [23:0] tfield;
    logic [23:0] mlen;
    logic [7:0]  mtype;
    logic [31:0] mstream;
    logic [31:0] ext;
    logic        is_ext;
    logic [1:0]  bsize;
    logic [3:0]  mhb;
    logic [23:0] pay;
  } hdr_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_header_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_chunk_format;
  logic [16:0] out_chunk_stream;
  logic [23:0] out_time_field;
  logic [23:0] out_message_length;
  logic [7:0]  out_message_type;
  logic [31:0] out_message_stream;
  logic [31:0] out_extended_time;
  logic        out_ext_read;
  logic [1:0]  out_basic_size;
  logic [3:0]  out_message_header_bytes;
  logic [23:0] out_payload_bytes;

  // Parser mirror
  rtmp_chp_pkg::phase_t psr_phase;
  logic [3:0]  psr_idx;
  logic [1:0]  psr_fmt;
  logic [16:0] psr_stream;
  logic [23:0] psr_time;
  logic [23:0] psr_len;
  logic [7:0]  psr_type;
  logic [31:0] psr_mstream;
  logic [31:0] psr_ext;
  logic [1:0]  psr_blen;
  bit          ext_seen [SLOTS];

  hdr_word_t   hdr_expect_q[$];
  int          err_count = 0;
  int          bytes_sent = 0;
  int          sink_wait = 0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  bit          hold_req = 1'b0;

  always #4 clk = ~clk;

  rtmp_chunk_header_parser_unit #(
    .STREAM_SLOTS(SLOTS)
  ) u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_header_byte           (in_header_byte),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_chunk_format         (out_chunk_format),
    .out_chunk_stream         (out_chunk_stream),
    .out_time_field           (out_time_field),
    .out_message_length       (out_message_length),
    .out_message_type         (out_message_type),
    .out_message_stream       (out_message_stream),
    .out_extended_time        (out_extended_time),
    .out_ext_read             (out_ext_read),
    .out_basic_size           (out_basic_size),
    .out_message_header_bytes (out_message_header_bytes),
    .out_payload_bytes        (out_payload_bytes)
  );

  function automatic void reset_parser_model();
    psr_phase   = rtmp_chp_pkg::PH_BASIC0;
    psr_idx     = '0;
    psr_fmt     = rtmp_chp_pkg::FMT_FULL;
    psr_stream  = '0;
    psr_time    = '0;
    psr_len     = '0;
    psr_type    = '0;
    psr_mstream = '0;
    psr_ext     = '0;
    psr_blen    = 2'd1;
    foreach (ext_seen[i]) ext_seen[i] = 1'b0;
  endfunction

  function automatic void finish_header(input bit ext_read);
    hdr_word_t w;
    bit        has_len;
    has_len = (psr_fmt == rtmp_chp_pkg::FMT_FULL) || (psr_fmt == rtmp_chp_pkg::FMT_NO_STREAM);
    if (psr_stream < SLOTS) ext_seen[psr_stream] = ext_read;
    w.fmt     = psr_fmt;
    w.stream  = psr_stream;
    w.tfield  = (psr_fmt != rtmp_chp_pkg::FMT_NONE) ? psr_time : '0;
    w.mlen    = has_len ? psr_len : '0;
    w.mtype   = has_len ? psr_type : '0;
    w.mstream = (psr_fmt == rtmp_chp_pkg::FMT_FULL) ? psr_mstream : '0;
    w.ext     = ext_read ? psr_ext : '0;
    w.is_ext  = ext_read;
    w.bsize   = psr_blen;
    w.mhb     = MSG_SPAN[psr_fmt];
    w.pay     = has_len ? psr_len : '0;
    hdr_expect_q.push_back(w);
    psr_phase = rtmp_chp_pkg::PH_BASIC0;
    psr_idx   = '0;
  endfunction

  function automatic void after_message_header();
    bit need;
    if (psr_fmt == rtmp_chp_pkg::FMT_NONE) need = (psr_stream < SLOTS) && ext_seen[psr_stream];
    else need = (psr_time == rtmp_chp_pkg::TIME_ESCAPE);
    if (need) begin
      psr_phase = rtmp_chp_pkg::PH_EXT;
      psr_idx   = '0;
    end else begin
      finish_header(1'b0);
    end
  endfunction

  function automatic void after_basic_header();
    if (MSG_SPAN[psr_fmt] != 4'd0) begin
      psr_phase = rtmp_chp_pkg::PH_MSG;
      psr_idx   = '0;
    end else begin
      after_message_header();
    end
  endfunction

  function automatic void parse_header_byte(input logic [7:0] hb);
    case (psr_phase)
      rtmp_chp_pkg::PH_BASIC0: begin
        psr_fmt     = hb[7:6];
        psr_time    = '0;
        psr_len     = '0;
        psr_type    = '0;
        psr_mstream = '0;
        psr_ext     = '0;
        psr_idx     = '0;
        if (hb[5:0] == rtmp_chp_pkg::LOW_TWO_BYTE || hb[5:0] == rtmp_chp_pkg::LOW_THREE_BYTE) begin
          psr_blen   = (hb[5:0] == rtmp_chp_pkg::LOW_TWO_BYTE) ? 2'd2 : 2'd3;
          psr_stream = rtmp_chp_pkg::LONG_ID_BASE;
          psr_phase  = rtmp_chp_pkg::PH_BASIC1;
        end else begin
          psr_blen   = 2'd1;
          psr_stream = 17'(hb[5:0]);
          after_basic_header();
        end
      end
      rtmp_chp_pkg::PH_BASIC1: begin
        psr_stream = rtmp_chp_pkg::LONG_ID_BASE + 17'(hb);
        if (psr_blen == 2'd3) psr_phase = rtmp_chp_pkg::PH_BASIC2;
        else after_basic_header();
      end
      rtmp_chp_pkg::PH_BASIC2: begin
        psr_stream = psr_stream + {1'b0, hb, 8'd0};
        after_basic_header();
      end
      rtmp_chp_pkg::PH_MSG: begin
        if (psr_idx < 4'd3) psr_time = {psr_time[15:0], hb};
        else if (psr_idx < 4'd6) psr_len = {psr_len[15:0], hb};
        else if (psr_idx == 4'd6) psr_type = hb;
        else if (psr_idx < 4'd11) psr_mstream = psr_mstream | (32'(hb) << (8 * (psr_idx - 7)));
        psr_idx = psr_idx + 4'd1;
        if (psr_idx >= MSG_SPAN[psr_fmt]) after_message_header();
      end
      rtmp_chp_pkg::PH_EXT: begin
        psr_ext = {psr_ext[23:0], hb};
        psr_idx = psr_idx + 4'd1;
        if (psr_idx >= rtmp_chp_pkg::EXT_BYTES) finish_header(1'b1);
      end
      default: begin
        psr_phase = rtmp_chp_pkg::PH_BASIC0;
        psr_idx   = '0;
      end
    endcase
  endfunction

  task automatic log_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) log_error($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic check_word();
    hdr_word_t want;
    if (hdr_expect_q.size() == 0) begin
      log_error($sformatf("unexpected word on chunk stream %0d", out_chunk_stream));
      return;
    end
    want = hdr_expect_q.pop_front();
    check_field("chunk_format", 32'(out_chunk_format), 32'(want.fmt));
    check_field("chunk_stream", 32'(out_chunk_stream), 32'(want.stream));
    check_field("time_field", 32'(out_time_field), 32'(want.tfield));
    check_field("message_length", 32'(out_message_length), 32'(want.mlen));
    check_field("message_type", 32'(out_message_type), 32'(want.mtype));
    check_field("message_stream", out_message_stream, want.mstream);
    check_field("extended_time", out_extended_time, want.ext);
    check_field("ext_read", 32'(out_ext_read), 32'(want.is_ext));
    check_field("basic_size", 32'(out_basic_size), 32'(want.bsize));
    check_field("message_header_bytes", 32'(out_message_header_bytes), 32'(want.mhb));
    check_field("payload_bytes", 32'(out_payload_bytes), 32'(want.pay));
  endtask

  // Result side: check each accepted word, then draw the stall before the next one
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        check_word();
        sink_wait = sink_quiet ? 0 : $urandom_range(0, 13);
      end
      if (hold_req) begin
        sink_wait = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (sink_wait > 0) begin
        out_stall <= 1'b1;
        sink_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] hb);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_header_byte <= hb;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    parse_header_byte(hb);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Drop valid and wait for a clock edge so a following send never reassigns it in the same step
  task automatic src_rest();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    src_rest();
    while (hdr_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_header();
    logic [7:0]  seq[$];
    logic [1:0]  f;
    logic [7:0]  lo_b;
    logic [7:0]  hi_b;
    logic [16:0] id;
    logic [23:0] t_val;
    logic [23:0] l_val;
    logic [31:0] s_val;
    int          shape;
    bit          need_ext;
    f     = 2'($urandom_range(0, 3));
    shape = $urandom_range(0, 9);
    lo_b  = 8'($urandom);
    if (shape < 6) begin
      // favor a few ids so format 3 often follows an extended header
      lo_b[5:0] = (shape < 3) ? 6'($urandom_range(2, 5)) : 6'($urandom_range(2, 63));
      seq.push_back({f, lo_b[5:0]});
      id = 17'(lo_b[5:0]);
    end else if (shape < 8) begin
      seq.push_back({f, rtmp_chp_pkg::LOW_TWO_BYTE});
      seq.push_back(lo_b);
      id = rtmp_chp_pkg::LONG_ID_BASE + 17'(lo_b);
    end else begin
      hi_b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      seq.push_back({f, rtmp_chp_pkg::LOW_THREE_BYTE});
      seq.push_back(lo_b);
      seq.push_back(hi_b);
      id = rtmp_chp_pkg::LONG_ID_BASE + 17'(lo_b) + {1'b0, hi_b, 8'd0};
    end
    case ($urandom_range(0, 7))
      0, 1:    t_val = rtmp_chp_pkg::TIME_ESCAPE;
      2:       t_val = rtmp_chp_pkg::TIME_ESCAPE - 24'd1;
      3:       t_val = '0;
      default: t_val = 24'($urandom);
    endcase
    l_val = 24'($urandom);
    s_val = $urandom;
    if (MSG_SPAN[f] != 4'd0) begin
      seq.push_back(t_val[23:16]);
      seq.push_back(t_val[15:8]);
      seq.push_back(t_val[7:0]);
    end
    if (f == rtmp_chp_pkg::FMT_FULL || f == rtmp_chp_pkg::FMT_NO_STREAM) begin
      seq.push_back(l_val[23:16]);
      seq.push_back(l_val[15:8]);
      seq.push_back(l_val[7:0]);
      seq.push_back(8'($urandom));
    end
    if (f == rtmp_chp_pkg::FMT_FULL) begin
      seq.push_back(s_val[7:0]);
      seq.push_back(s_val[15:8]);
      seq.push_back(s_val[23:16]);
      seq.push_back(s_val[31:24]);
    end
    if (f == rtmp_chp_pkg::FMT_NONE) need_ext = (id < SLOTS) && ext_seen[id];
    else need_ext = (t_val == rtmp_chp_pkg::TIME_ESCAPE);
    if (need_ext) repeat (4) seq.push_back(8'($urandom));
    send_seq(seq);
  endtask

  // Raw bytes, then keep going until the parser is back at a header start
  task automatic random_noise();
    repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
    while (psr_phase != rtmp_chp_pkg::PH_BASIC0) send_byte(8'($urandom));
  endtask

  task automatic test_directed_forms();
    logic [7:0] seq[$];
    seq = '{
      8'hC2,
      // format 0, two-byte id 64, escaped time, all-ones fields
      8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01,
      // format 3 on id 64 inherits the extended timestamp
      8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      // format 2, three-byte id 65599 (beyond the flag table), escaped
      8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78,
      // format 3 on an id beyond the table: no extension
      8'hC1, 8'hFF, 8'hFF,
      // format 1, id 63, all-zero fields
      8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    send_seq(seq);
  endtask

  task automatic test_backpressure();
    src_quiet = 1'b1;
    hold_req  = 1'b1;
    repeat (30) random_header();
    src_quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (12) random_header();
    wait_for_drain();
    repeat (12) random_header();
  endtask

  task automatic test_random_mix();
    int n_hdr;
    n_hdr = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (n_hdr % 40 == 0) begin
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 6) == 0) random_noise();
      else random_header();
      n_hdr++;
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    reset_parser_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_forms();
    test_backpressure();
    test_drain_pause();
    test_random_mix();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- rtmp_chunk_header_parser_unit.f -----
design/rtmp_chp_pkg.sv
design/rtmp_chp_ram.sv
design/rtmp_chunk_header_parser_unit.sv
design/rtmp_chp_checker.sv
verif/tb_top.sv
